FILE: rtl/pwmm_pkg.sv
// Shared types and constants for the PWM period and duty meter.
`default_nettype none

package pwmm_pkg;

    // Field widths of the configuration register and of a result word
    localparam int TICK_RATE_W = 24;
    localparam int HIGH_W      = 16;
    localparam int LOW_W       = 16;
    localparam int PERIOD_W    = 17;
    localparam int DUTY_W      = 7;
    localparam int FREQ_W      = 30;

    // Tick rate after reset, and the scale used for duty and centihertz
    localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = 24'd2000000;
    localparam int                     DUTY_SCALE      = 100;

    // Measurement queue fill level when full
    localparam logic [1:0] QUEUE_FULL_LEVEL = 2'd2;

    // Queue status seen by both the capture side and the divider side
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Edge capture phase
    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } t_phase;

    // Divider sequencer state
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_DUTY = 5'b00100,
        S_FREQ = 5'b01000,
        S_DONE = 5'b10000
    } t_div_state;

endpackage

`default_nettype wire

FILE: rtl/pwmm_if.sv
// Valid/ready channel interfaces for level samples and measurement results.
`default_nettype none

interface pwmm_in_if;
    logic valid;
    logic ready;
    logic level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

interface pwmm_out_if import pwmm_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [HIGH_W-1:0]   high_ticks;
    logic [LOW_W-1:0]    low_ticks;
    logic [PERIOD_W-1:0] period_ticks;
    logic [DUTY_W-1:0]   duty_percent;
    logic [FREQ_W-1:0]   freq_centihz;

    modport source (
        output valid, output high_ticks, output low_ticks, output period_ticks,
        output duty_percent, output freq_centihz, input ready
    );
    modport sink (
        input valid, input high_ticks, input low_ticks, input period_ticks,
        input duty_percent, input freq_centihz, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/pwmm_queue.sv
// Two-entry measurement queue between edge capture and the divider.
`default_nettype none

module pwmm_queue import pwmm_pkg::*; #(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_push_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_pop_data,
    output t_q_stat           o_stat
);

    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;
    logic [1:0]   n_cnt;

    // Present the head entry
    assign o_pop_data   = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == QUEUE_FULL_LEVEL);
    assign o_stat.empty = (r_cnt == 2'd0);

    // Track fill level
    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_push_data;
    end

endmodule

`default_nettype wire

FILE: rtl/pwmm_front.sv
// Edge capture: counts high and low phase ticks and queues each finished period.
`default_nettype none

module pwmm_front import pwmm_pkg::*; #(
    parameter int CW = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    pwmm_in_if.sink         i_in,
    input  t_q_stat         i_q_stat,
    output logic            o_push,
    output logic [2*CW-1:0] o_push_data
);

    localparam logic [CW-1:0] CMAX = {CW{1'b1}};

    t_phase        r_phase, n_phase;
    logic          r_prev,  n_prev;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [CW-1:0] r_held,  n_held;
    logic [CW-1:0] cnt_inc;
    logic          acc;

    // Take a sample whenever the queue can absorb a result
    assign i_in.ready  = !i_q_stat.full;
    assign acc         = i_in.valid && !i_q_stat.full;
    assign cnt_inc     = (r_cnt == CMAX) ? r_cnt : r_cnt + 1'b1;
    assign o_push_data = {r_held, r_cnt};

    // Phase sequencing on each accepted sample
    always_comb begin
        n_phase = r_phase;
        n_prev  = r_prev;
        n_cnt   = r_cnt;
        n_held  = r_held;
        o_push  = 1'b0;
        if (acc) begin
            n_prev = i_in.level;
            unique case (r_phase)
                PH_HIGH: begin
                    if (!i_in.level) begin
                        n_held  = r_cnt;
                        n_cnt   = CW'(1);
                        n_phase = PH_LOW;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                PH_LOW: begin
                    if (i_in.level) begin
                        o_push  = 1'b1;
                        n_cnt   = '0;
                        n_phase = PH_WAIT;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                default: begin
                    n_phase = PH_WAIT;
                    if (i_in.level && !r_prev) begin
                        n_cnt   = CW'(1);
                        n_phase = PH_HIGH;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_prev  <= 1'b0;
            r_cnt   <= '0;
            r_held  <= '0;
        end else begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_cnt   <= n_cnt;
            r_held  <= n_held;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pwmm_back.sv
// Result side: bit-serial division for duty and frequency, and the output register.
`default_nettype none

module pwmm_back import pwmm_pkg::*; #(
    parameter int CW = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [TICK_RATE_W-1:0] i_tick_rate,
    input  t_q_stat                     i_q_stat,
    input  wire logic [2*CW-1:0]        i_pop_data,
    output logic                        o_pop,
    pwmm_out_if.source                  o_out
);

    localparam int DW   = (CW + 7 > 31) ? CW + 7 : 31;
    localparam int RW   = CW + 2;
    localparam int CNTW = $clog2(DW);

    t_div_state      r_state, n_state;
    logic [CW-1:0]   r_hi, n_hi;
    logic [CW-1:0]   r_lo, n_lo;
    logic [CW:0]     r_per, n_per;
    logic [DW-1:0]   r_dvd, n_dvd;
    logic [RW-1:0]   r_rem, n_rem;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [DUTY_W-1:0] r_duty, n_duty;
    logic            r_out_valid, n_out_valid;
    logic            load_out;

    logic [HIGH_W-1:0]   r_out_high;
    logic [LOW_W-1:0]    r_out_low;
    logic [PERIOD_W-1:0] r_out_period;
    logic [DUTY_W-1:0]   r_out_duty;
    logic [FREQ_W-1:0]   r_out_freq;

    logic [RW-1:0] rem_sh, rem_nx, per_ext;
    logic [DW-1:0] quot_nx, hi_ext, rate_ext, duty_dvd, freq_dvd;
    logic          ge;

    // One restoring division step; quotient bits shift into the dividend register
    assign per_ext = {1'b0, r_per};
    assign rem_sh  = {r_rem[RW-2:0], r_dvd[DW-1]};
    assign ge      = (rem_sh >= per_ext);
    assign rem_nx  = ge ? rem_sh - per_ext : rem_sh;
    assign quot_nx = {r_dvd[DW-2:0], ge};

    // Scale by 100 as shifts and adds
    assign hi_ext   = DW'(r_hi);
    assign rate_ext = DW'(i_tick_rate);
    assign duty_dvd = (hi_ext << 6) + (hi_ext << 5) + (hi_ext << 2);
    assign freq_dvd = (rate_ext << 6) + (rate_ext << 5) + (rate_ext << 2);

    // Drive the result channel
    assign o_out.valid        = r_out_valid;
    assign o_out.high_ticks   = r_out_high;
    assign o_out.low_ticks    = r_out_low;
    assign o_out.period_ticks = r_out_period;
    assign o_out.duty_percent = r_out_duty;
    assign o_out.freq_centihz = r_out_freq;

    // Sequence: fetch, load duty dividend, divide duty, divide frequency, hand over
    always_comb begin
        n_state     = r_state;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_per       = r_per;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_duty      = r_duty;
        n_out_valid = r_out_valid && !o_out.ready;
        o_pop       = 1'b0;
        load_out    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_hi    = i_pop_data[2*CW-1:CW];
                    n_lo    = i_pop_data[CW-1:0];
                    n_per   = {1'b0, i_pop_data[2*CW-1:CW]} + {1'b0, i_pop_data[CW-1:0]};
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_dvd   = duty_dvd;
                n_rem   = '0;
                n_cnt   = CNTW'(DW - 1);
                n_state = S_DUTY;
            end
            S_DUTY: begin
                n_dvd = quot_nx;
                n_rem = rem_nx;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_duty  = quot_nx[DUTY_W-1:0];
                    n_dvd   = freq_dvd;
                    n_rem   = '0;
                    n_cnt   = CNTW'(DW - 1);
                    n_state = S_FREQ;
                end
            end
            S_FREQ: begin
                n_dvd = quot_nx;
                n_rem = rem_nx;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload; a zero period forces zero duty and frequency
    always_ff @(posedge i_clk) begin
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_per  <= n_per;
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_duty <= n_duty;
        if (load_out) begin
            r_out_high   <= HIGH_W'(r_hi);
            r_out_low    <= LOW_W'(r_lo);
            r_out_period <= PERIOD_W'(r_per);
            r_out_duty   <= (r_per == '0) ? '0 : r_duty;
            r_out_freq   <= (r_per == '0) ? '0 : r_dvd[FREQ_W-1:0];
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_stat.empty)
        else $error("queue popped while empty");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_duty <= DUTY_W'(DUTY_SCALE)))
        else $error("duty above full scale");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside hand-over state");

    a_duty_to_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUTY && r_cnt == '0) |=> (r_state == S_FREQ))
        else $error("frequency division did not follow duty division");
`endif

endmodule

`default_nettype wire

FILE: rtl/pwm_period_duty_meter_top.sv
// Path: the closing sample pushes a word into the queue; the divider pops it, divides
//   duty, then frequency, on DW-bit dividends (DW = max(COUNT_WIDTH+7, 31)), then loads the output register.
// Throughput: one level sample per cycle while the two-word queue has room; the shared
//   one-bit-per-cycle divider handles one period at a time and fetches the next after the load.
// Reset: synchronous, active low; clears phase, counts, queue and divider, and
//   returns the tick rate to 2000000 Hz.
`default_nettype none

module pwm_period_duty_meter_top import pwmm_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [TICK_RATE_W-1:0] i_cfg_wdata,
    pwmm_in_if.sink                     i_in,
    pwmm_out_if.source                  o_out
);

    logic [TICK_RATE_W-1:0]   r_tick_rate;
    logic                     push;
    logic                     pop;
    logic [2*COUNT_WIDTH-1:0] push_data;
    logic [2*COUNT_WIDTH-1:0] pop_data;
    t_q_stat                  q_stat;

    // Hold the tick rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= TICK_RATE_RESET;
        end else if (i_cfg_we) begin
            r_tick_rate <= i_cfg_wdata;
        end
    end

    pwmm_front #(.CW(COUNT_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    pwmm_queue #(.W(2*COUNT_WIDTH)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_stat      (q_stat)
    );

    pwmm_back #(.CW(COUNT_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick_rate (r_tick_rate),
        .i_q_stat    (q_stat),
        .i_pop_data  (pop_data),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
